FILE: rtl/core/zdp_pkg.sv
// Shared constants and codes for the z-normalized distance profile unit.
// No dependencies; zdp_in_if, zdp_out_if, zdp_div and the top level refer to this package.
package zdp_pkg;

    localparam int MAX_QUERY_LEN = 128;
    localparam int SAMPLE_BITS   = 16;

    localparam int DIST_W     = 24;
    localparam int POS_W      = 16;
    localparam int MLEN_W     = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_SHIFT = 18;
    localparam int CORR_BITS  = 30;

    localparam int MLEN_RESET = 128;
    localparam int SLEN_RESET = 1024;
    localparam int MLEN_MIN   = 2;
    localparam int SLEN_MIN   = 3;

    localparam logic MODE_QUERY  = 1'b0;
    localparam logic MODE_SERIES = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUERY_LENGTH  = 2'd0,
        REG_SERIES_LENGTH = 2'd1
    } t_reg_idx;

endpackage

FILE: rtl/core/zdp_in_if.sv
// Input channel of the distance profile unit: valid/ready plus one sample word.
// Depends on zdp_pkg for the default sample width.
interface zdp_in_if #(
    parameter int SAMPLE_BITS = zdp_pkg::SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output mode, output sample, input ready);
    modport sink   (input valid, input mode, input sample, output ready);
endinterface

FILE: rtl/core/zdp_out_if.sv
// Result channel of the distance profile unit: valid/ready plus one result word.
// Depends on zdp_pkg for the field widths.
interface zdp_out_if ();
    logic                              valid;
    logic                              ready;
    logic [zdp_pkg::DIST_W-1:0]        distance;
    logic [zdp_pkg::POS_W-1:0]         window_start;
    logic                              degenerate;
    logic                              last_of_series;

    modport source (output valid, output distance, output window_start,
                    output degenerate, output last_of_series, input ready);
    modport sink   (input valid, input distance, input window_start,
                    input degenerate, input last_of_series, output ready);
endinterface

FILE: rtl/core/zdp_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies.
module zdp_ram #(
    parameter int DEPTH = 128,
    parameter int W     = 16,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/zdp_sqrt.sv
// Iterative integer square root, one result bit per cycle (floor of sqrt).
// No dependencies.
module zdp_sqrt #(
    parameter int W = 66
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  logic [W-1:0]   i_arg,
    output logic           o_done,
    output logic [W/2-1:0] o_root
);
    logic [W-1:0] r_x;
    logic [W-1:0] r_res;
    logic [W-1:0] r_bit;
    logic         r_busy;
    logic         r_done;
    logic [W-1:0] n_sum;
    logic         n_ge;

    assign n_sum = r_res + r_bit;
    assign n_ge  = (r_x >= n_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_x   <= i_arg;
            r_res <= '0;
            r_bit <= {2'b01, {(W-2){1'b0}}};
        end else if (r_busy) begin
            if (n_ge) begin
                r_x   <= r_x - n_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[W/2-1:0];
endmodule

FILE: rtl/core/zdp_div.sv
// Restoring fraction divider: quotient of num/den with num < den, one bit per cycle.
// Depends on zdp_pkg for the quotient width.
module zdp_div #(
    parameter int R_W = 67
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [R_W-1:0]                i_num,
    input  logic [R_W-1:0]                i_den,
    output logic                          o_done,
    output logic [zdp_pkg::CORR_BITS-1:0] o_quot
);
    localparam int QW    = zdp_pkg::CORR_BITS;
    localparam int CNT_W = $clog2(QW);

    logic [R_W-1:0]   r_rem;
    logic [R_W-1:0]   r_den;
    logic [QW-1:0]    r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [R_W-1:0]   n_shift;

    assign n_shift = {r_rem[R_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            if (n_shift >= r_den) begin
                r_rem  <= n_shift - r_den;
                r_quot <= {r_quot[QW-2:0], 1'b1};
            end else begin
                r_rem  <= n_shift;
                r_quot <= {r_quot[QW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

FILE: rtl/core/znorm_distance_profile_unit.sv
// Top level of the z-normalized distance profile unit.
// Depends on zdp_pkg, zdp_in_if, zdp_out_if, zdp_ram, zdp_sqrt and zdp_div.
//
// The unit holds a query of m samples and, for every series sample once m
// series samples are present, emits the z-normalized Euclidean distance
// sqrt(2m(1-corr)) in unsigned Q8.16 together with the window's start index.
// Query words (mode 0) are taken one per cycle; the last one fixes the query
// statistics in S_QMUL and S_QV and, at non-zero variance, in a square root
// run, whose operand width is 66 bits at the default widths. A series word
// that completes no window passes through S_UPD and S_UPD2 back to idle. A
// series word that completes a window goes on to the dot product, which reads
// one query entry and one window entry per cycle from the two sample memories;
// at non-zero variance the shared bit-serial square root unit runs twice and
// a bit-serial divider forms the correlation unless its magnitude saturates
// at one. The input is taken only between items, but a finished result sits
// in an output register, so the next word is accepted while that result waits.
// A window or query with zero variance reports distance 0 with the degenerate
// flag set. A length register write drops the query and restarts the series.
module znorm_distance_profile_unit #(
    parameter int MAX_QUERY_LEN = zdp_pkg::MAX_QUERY_LEN,
    parameter int SAMPLE_BITS   = zdp_pkg::SAMPLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    zdp_in_if.sink                            i_in,
    zdp_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [zdp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [zdp_pkg::CFG_W-1:0]         i_cfg_data
);
    localparam int SB     = SAMPLE_BITS;
    localparam int RP_W   = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;
    localparam int XW     = RP_W + 1;
    localparam int ML     = $clog2(MAX_QUERY_LEN + 1);
    localparam int SUM_W  = SB + ML;
    localparam int SQS_W  = 2 * SB + ML;
    localparam int DOT_W  = 2 * SB + ML;
    localparam int V_W    = 2 * SB + 2 * ML;
    localparam int FRAC   = zdp_pkg::FRAC_SHIFT;
    localparam int SQ_W   = V_W + FRAC;
    localparam int ROOT_W = SQ_W / 2;
    localparam int D_W    = 2 * ROOT_W;
    localparam int R_W    = D_W + 1;
    localparam int CORR   = zdp_pkg::CORR_BITS;
    localparam int C_W    = CORR + 1;
    localparam int T_W    = CORR + 2;
    localparam int POS_W  = zdp_pkg::POS_W;
    localparam int PW     = POS_W + 1;
    localparam int DIST_W = zdp_pkg::DIST_W;
    localparam int M_RST  = (zdp_pkg::MLEN_RESET > MAX_QUERY_LEN) ?
                            MAX_QUERY_LEN : zdp_pkg::MLEN_RESET;

    typedef enum logic [4:0] {
        S_IDLE, S_QMUL, S_QV, S_QSQ, S_UPD, S_UPD2, S_DOT, S_MUL,
        S_VAR, S_SQW, S_DPROD, S_CMP, S_DIV, S_TERM, S_VAL, S_FSQ, S_FIN
    } t_state;

    // Seventeen states need five bits.
    t_state r_state;

    // Configuration and sequence state.
    logic [ML-1:0]          r_m;
    logic [POS_W-1:0]       r_n;
    logic [RP_W-1:0]        r_fill;
    logic                   r_qready;
    logic                   r_vq0;
    logic [ROOT_W-1:0]      r_rq;
    logic signed [SUM_W-1:0] r_qs;
    logic signed [SQS_W-1:0] r_qss;
    logic signed [SUM_W-1:0] r_ws;
    logic signed [SQS_W-1:0] r_wss;
    logic [RP_W-1:0]        r_rp;
    logic [POS_W-1:0]       r_pos;

    // Per-window working registers.
    logic signed [SB-1:0]    r_s;
    logic signed [SQS_W-1:0] r_s2;
    logic signed [SQS_W-1:0] r_old2;
    logic                    r_hasold;
    logic [RP_W-1:0]         r_dptr;
    logic [ML-1:0]           r_cnt;
    logic                    r_rdv;
    logic                    r_pv;
    logic signed [2*SB-1:0]  r_prod;
    logic signed [DOT_W-1:0] r_acc;
    logic signed [V_W:0]     r_ta;
    logic signed [V_W:0]     r_tb;
    logic signed [V_W:0]     r_tc;
    logic signed [V_W:0]     r_td;
    logic signed [V_W:0]     r_cov;
    logic [ROOT_W-1:0]       r_rw;
    logic [D_W-1:0]          r_d;
    logic [R_W-1:0]          r_num;
    logic [C_W-1:0]          r_c;
    logic [T_W-1:0]          r_t;
    logic [SQ_W-1:0]         r_sq_arg;
    logic                    r_sq_go;
    logic                    r_div_go;
    logic [POS_W-1:0]        r_wstart;
    logic                    r_last;
    logic [DIST_W-1:0]       r_wdist;
    logic                    r_wdg;

    // Output register.
    logic                    r_ov;
    logic [DIST_W-1:0]       r_dist;
    logic                    r_dg;
    logic [POS_W-1:0]        r_ows;
    logic                    r_olast;

    // Memories and arithmetic units.
    logic [SB-1:0]           q_rdata;
    logic [SB-1:0]           w_rdata;
    logic [RP_W-1:0]         w_raddr;
    logic                    q_we;
    logic                    w_we;
    logic                    sq_done;
    logic [ROOT_W-1:0]       sq_root;
    logic                    div_done;
    logic [CORR-1:0]         div_quot;

    logic                    in_acc;
    logic signed [SB-1:0]    s_in;
    logic signed [SQS_W-1:0] x_s;
    logic signed [SQS_W-1:0] n_s2;
    logic signed [SB-1:0]    n_old;
    logic signed [SQS_W-1:0] x_old;
    logic signed [2*SB-1:0]  x_q;
    logic signed [2*SB-1:0]  x_w;
    logic signed [V_W:0]     x_m;
    logic signed [V_W:0]     x_qs;
    logic signed [V_W:0]     x_qss;
    logic signed [V_W:0]     x_ws;
    logic signed [V_W:0]     x_wss;
    logic signed [V_W:0]     x_dot;
    logic signed [V_W:0]     n_diff;
    logic signed [V_W:0]     n_cov;
    logic [V_W:0]            n_mag;
    logic [SQ_W-1:0]         n_mt;
    logic [DIST_W+ROOT_W-1:0] n_root_ext;
    logic [RP_W-1:0]         n_old_addr;
    logic [RP_W-1:0]         n_base;
    logic [RP_W-1:0]         n_rp_inc;
    logic [RP_W-1:0]         n_dptr_inc;
    logic                    n_restart;
    logic                    n_out_free;
    logic [ML-1:0]           n_m_cfg;
    logic [POS_W-1:0]        n_n_cfg;

    // Index into a ring of MAX_QUERY_LEN entries for a value below twice that.
    function automatic logic [RP_W-1:0] wrap_idx(input logic [XW-1:0] x);
        logic [XW-1:0] y;
        y = (x >= XW'(MAX_QUERY_LEN)) ? x - XW'(MAX_QUERY_LEN) : x;
        return y[RP_W-1:0];
    endfunction

    assign in_acc = i_in.valid && (r_state == S_IDLE);
    assign s_in   = i_in.sample;

    assign x_s   = {{(SQS_W-SB){s_in[SB-1]}}, s_in};
    assign n_s2  = x_s * x_s;
    assign n_old = r_hasold ? $signed(w_rdata) : '0;
    assign x_old = {{(SQS_W-SB){n_old[SB-1]}}, n_old};
    assign x_q   = {{SB{q_rdata[SB-1]}}, q_rdata};
    assign x_w   = {{SB{w_rdata[SB-1]}}, w_rdata};

    assign x_m   = $signed({{(V_W+1-ML){1'b0}}, r_m});
    assign x_qs  = {{(V_W+1-SUM_W){r_qs[SUM_W-1]}}, r_qs};
    assign x_qss = {{(V_W+1-SQS_W){r_qss[SQS_W-1]}}, r_qss};
    assign x_ws  = {{(V_W+1-SUM_W){r_ws[SUM_W-1]}}, r_ws};
    assign x_wss = {{(V_W+1-SQS_W){r_wss[SQS_W-1]}}, r_wss};
    assign x_dot = {{(V_W+1-DOT_W){r_acc[DOT_W-1]}}, r_acc};

    assign n_diff = r_ta - r_tb;
    assign n_cov  = r_tc - r_td;
    assign n_mag  = r_cov[V_W] ? $unsigned(-r_cov) : $unsigned(r_cov);
    assign n_mt   = {{(SQ_W-ML){1'b0}}, r_m} * {{(SQ_W-T_W){1'b0}}, r_t};
    assign n_root_ext = {{DIST_W{1'b0}}, sq_root};

    assign n_old_addr = wrap_idx({1'b0, r_rp} + XW'(MAX_QUERY_LEN) - XW'(r_m));
    assign n_base     = wrap_idx({1'b0, r_rp} + XW'(MAX_QUERY_LEN) - XW'(r_m) + XW'(1));
    assign n_rp_inc   = wrap_idx({1'b0, r_rp} + XW'(1));
    assign n_dptr_inc = wrap_idx({1'b0, r_dptr} + XW'(1));
    assign n_restart  = ({1'b0, r_pos} + PW'(1)) >= {1'b0, r_n};
    assign n_out_free = !r_ov || o_out.ready;

    // Configuration values clamped to their legal ranges.
    always_comb begin
        if (i_cfg_data[zdp_pkg::MLEN_W-1:0] < zdp_pkg::MLEN_W'(zdp_pkg::MLEN_MIN)) begin
            n_m_cfg = ML'(zdp_pkg::MLEN_MIN);
        end else if (int'(i_cfg_data[zdp_pkg::MLEN_W-1:0]) > MAX_QUERY_LEN) begin
            n_m_cfg = ML'(MAX_QUERY_LEN);
        end else begin
            n_m_cfg = ML'(i_cfg_data[zdp_pkg::MLEN_W-1:0]);
        end
        if (i_cfg_data[POS_W-1:0] < POS_W'(zdp_pkg::SLEN_MIN)) begin
            n_n_cfg = POS_W'(zdp_pkg::SLEN_MIN);
        end else begin
            n_n_cfg = i_cfg_data[POS_W-1:0];
        end
    end

    assign q_we    = in_acc && (i_in.mode == zdp_pkg::MODE_QUERY);
    assign w_we    = (r_state == S_UPD);
    assign w_raddr = (r_state == S_DOT) ? r_dptr : n_old_addr;

    zdp_ram #(.DEPTH(MAX_QUERY_LEN), .W(SB), .AW(RP_W)) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_fill),
        .i_wdata (s_in),
        .i_raddr (r_cnt[RP_W-1:0]),
        .o_rdata (q_rdata)
    );

    zdp_ram #(.DEPTH(MAX_QUERY_LEN), .W(SB), .AW(RP_W)) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_rp),
        .i_wdata (r_s),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    zdp_sqrt #(.W(SQ_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_sq_go),
        .i_arg   (r_sq_arg),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    zdp_div #(.R_W(R_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (r_num),
        .i_den   ({1'b0, r_d}),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Sequencer: query load, window update, dot product and the distance math.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_m      <= ML'(M_RST);
            r_n      <= POS_W'(zdp_pkg::SLEN_RESET);
            r_fill   <= '0;
            r_qready <= 1'b0;
            r_qs     <= '0;
            r_qss    <= '0;
            r_ws     <= '0;
            r_wss    <= '0;
            r_rp     <= '0;
            r_pos    <= '0;
            r_sq_go  <= 1'b0;
            r_div_go <= 1'b0;
            r_rdv    <= 1'b0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_sq_go  <= 1'b0;
            r_div_go <= 1'b0;
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (zdp_pkg::t_reg_idx'(i_cfg_idx))
                    zdp_pkg::REG_QUERY_LENGTH: begin
                        r_m      <= n_m_cfg;
                        r_fill   <= '0;
                        r_qready <= 1'b0;
                        r_qs     <= '0;
                        r_qss    <= '0;
                        r_pos    <= '0;
                        r_rp     <= '0;
                        r_ws     <= '0;
                        r_wss    <= '0;
                    end
                    zdp_pkg::REG_SERIES_LENGTH: begin
                        r_n      <= n_n_cfg;
                        r_fill   <= '0;
                        r_qready <= 1'b0;
                        r_qs     <= '0;
                        r_qss    <= '0;
                        r_pos    <= '0;
                        r_rp     <= '0;
                        r_ws     <= '0;
                        r_wss    <= '0;
                    end
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.mode == zdp_pkg::MODE_QUERY) begin
                        r_qready <= 1'b0;
                        if (r_fill == '0) begin
                            r_qs  <= {{ML{s_in[SB-1]}}, s_in};
                            r_qss <= n_s2;
                        end else begin
                            r_qs  <= r_qs + {{ML{s_in[SB-1]}}, s_in};
                            r_qss <= r_qss + n_s2;
                        end
                        if (ML'(r_fill) + ML'(1) >= r_m) begin
                            r_fill  <= '0;
                            r_pos   <= '0;
                            r_rp    <= '0;
                            r_ws    <= '0;
                            r_wss   <= '0;
                            r_state <= S_QMUL;
                        end else begin
                            r_fill <= r_fill + RP_W'(1);
                        end
                    end else if (in_acc && r_qready) begin
                        r_s      <= s_in;
                        r_s2     <= n_s2;
                        r_hasold <= {1'b0, r_pos} >= PW'(r_m);
                        r_state  <= S_UPD;
                    end
                end
                S_QMUL: begin
                    r_ta    <= x_m * x_qss;
                    r_tb    <= x_qs * x_qs;
                    r_state <= S_QV;
                end
                S_QV: begin
                    r_vq0 <= (n_diff == '0);
                    if (n_diff == '0) begin
                        r_qready <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_sq_arg <= {n_diff[V_W-1:0], {FRAC{1'b0}}};
                        r_sq_go  <= 1'b1;
                        r_state  <= S_QSQ;
                    end
                end
                S_QSQ: begin
                    if (sq_done) begin
                        r_rq     <= sq_root;
                        r_qready <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_UPD: begin
                    // The oldest window sample leaves as the new one enters.
                    r_ws    <= r_ws - {{ML{n_old[SB-1]}}, n_old} + {{ML{r_s[SB-1]}}, r_s};
                    r_old2  <= x_old * x_old;
                    r_state <= S_UPD2;
                end
                S_UPD2: begin
                    r_wss <= r_wss - r_old2 + r_s2;
                    if (({1'b0, r_pos} + PW'(1)) >= PW'(r_m)) begin
                        r_wstart <= POS_W'(r_pos + POS_W'(1) - POS_W'(r_m));
                        r_last   <= ({1'b0, r_pos} + PW'(1)) == {1'b0, r_n};
                        r_dptr   <= n_base;
                        r_cnt    <= '0;
                        r_acc    <= '0;
                        r_rdv    <= 1'b0;
                        r_pv     <= 1'b0;
                        r_state  <= S_DOT;
                    end else begin
                        if (n_restart) begin
                            r_pos <= '0;
                            r_rp  <= '0;
                            r_ws  <= '0;
                            r_wss <= '0;
                        end else begin
                            r_pos <= r_pos + POS_W'(1);
                            r_rp  <= n_rp_inc;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_DOT: begin
                    // Read, multiply and accumulate form a three-deep pipeline.
                    if (r_cnt != r_m) begin
                        r_cnt  <= r_cnt + ML'(1);
                        r_dptr <= n_dptr_inc;
                        r_rdv  <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                    end
                    if (r_rdv) begin
                        r_prod <= x_q * x_w;
                    end
                    r_pv <= r_rdv;
                    if (r_pv) begin
                        r_acc <= r_acc + {{ML{r_prod[2*SB-1]}}, r_prod};
                    end
                    if (r_cnt == r_m && !r_rdv && !r_pv) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_ta    <= x_m * x_wss;
                    r_tb    <= x_ws * x_ws;
                    r_tc    <= x_m * x_dot;
                    r_td    <= x_qs * x_ws;
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    r_cov <= n_cov;
                    if (r_vq0 || n_diff == '0) begin
                        r_wdist <= '0;
                        r_wdg   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_wdg    <= 1'b0;
                        r_sq_arg <= {n_diff[V_W-1:0], {FRAC{1'b0}}};
                        r_sq_go  <= 1'b1;
                        r_state  <= S_SQW;
                    end
                end
                S_SQW: begin
                    if (sq_done) begin
                        r_rw    <= sq_root;
                        r_state <= S_DPROD;
                    end
                end
                S_DPROD: begin
                    r_d     <= {{ROOT_W{1'b0}}, r_rq} * {{ROOT_W{1'b0}}, r_rw};
                    r_num   <= {n_mag[V_W-1:0], {FRAC{1'b0}}, 1'b0} >> 1;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // Correlation magnitude of one or more saturates.
                    if (r_num >= {1'b0, r_d}) begin
                        r_c     <= {1'b1, {CORR{1'b0}}};
                        r_state <= S_TERM;
                    end else begin
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_c     <= {1'b0, div_quot};
                        r_state <= S_TERM;
                    end
                end
                S_TERM: begin
                    if (r_cov[V_W]) begin
                        r_t <= {2'b01, {CORR{1'b0}}} + {1'b0, r_c};
                    end else begin
                        r_t <= {2'b01, {CORR{1'b0}}} - {1'b0, r_c};
                    end
                    r_state <= S_VAL;
                end
                S_VAL: begin
                    r_sq_arg <= {n_mt[SQ_W-4:0], 3'b000};
                    r_sq_go  <= 1'b1;
                    r_state  <= S_FSQ;
                end
                S_FSQ: begin
                    if (sq_done) begin
                        r_wdist <= n_root_ext[DIST_W-1:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (n_out_free) begin
                        r_ov    <= 1'b1;
                        r_dist  <= r_wdist;
                        r_dg    <= r_wdg;
                        r_ows   <= r_wstart;
                        r_olast <= r_last;
                        if (n_restart) begin
                            r_pos <= '0;
                            r_rp  <= '0;
                            r_ws  <= '0;
                            r_wss <= '0;
                        end else begin
                            r_pos <= r_pos + POS_W'(1);
                            r_rp  <= n_rp_inc;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_ov;
    assign o_out.distance       = r_dist;
    assign o_out.window_start   = r_ows;
    assign o_out.degenerate     = r_dg;
    assign o_out.last_of_series = r_olast;

    // A series word is only worked on while a complete query is held.
    a_upd_needs_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> r_qready)
        else $error("series word processed without a ready query");

    // The dot product never issues more reads than the query holds.
    a_dot_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOT) |-> (r_cnt <= r_m))
        else $error("dot product read count overran the query length");

    // The divider reports completion only while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    // A pending result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_ov && !o_out.ready) |=> (r_state == S_FIN))
        else $error("result register loaded while still occupied");

endmodule

FILE: tb/znorm_distance_profile_unit_tb.sv
// Self-checking testbench for the z-normalized distance profile unit.
// Depends on zdp_pkg, zdp_in_if, zdp_out_if and the znorm_distance_profile_unit RTL.
// A built-in predictor models every accepted word; results are checked in order.
module znorm_distance_profile_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_QUERY_LEN = zdp_pkg::MAX_QUERY_LEN;
    localparam int SAMPLE_BITS   = zdp_pkg::SAMPLE_BITS;
    localparam int DIST_W        = zdp_pkg::DIST_W;
    localparam int POS_W         = zdp_pkg::POS_W;
    localparam int MLEN_W        = zdp_pkg::MLEN_W;
    localparam int CFG_W         = zdp_pkg::CFG_W;
    localparam int CFG_IDX_W     = zdp_pkg::CFG_IDX_W;
    localparam int FRAC_SHIFT    = zdp_pkg::FRAC_SHIFT;
    localparam int CORR_BITS     = zdp_pkg::CORR_BITS;
    localparam int MLEN_RESET    = zdp_pkg::MLEN_RESET;
    localparam int SLEN_RESET    = zdp_pkg::SLEN_RESET;
    localparam int MLEN_MIN      = zdp_pkg::MLEN_MIN;
    localparam int SLEN_MIN      = zdp_pkg::SLEN_MIN;
    localparam logic MODE_QUERY  = zdp_pkg::MODE_QUERY;
    localparam logic MODE_SERIES = zdp_pkg::MODE_SERIES;

    typedef zdp_pkg::t_reg_idx t_reg_idx;
    localparam t_reg_idx REG_QUERY_LENGTH  = zdp_pkg::REG_QUERY_LENGTH;
    localparam t_reg_idx REG_SERIES_LENGTH = zdp_pkg::REG_SERIES_LENGTH;

    localparam int SETTLE_CYCLES = 400;   // well above the longest window latency
    localparam int TARGET_WORDS  = 1550;

    typedef struct packed {
        logic                    mode;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_word;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [POS_W-1:0]  window_start;
        logic              degenerate;
        logic              last_of_series;
    } t_dist_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    zdp_in_if  in_ch ();
    zdp_out_if out_ch ();

    znorm_distance_profile_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Words waiting to be sent and distances still owed by the unit.
    t_word        word_q[$];
    t_dist_result dist_q[$];

    int error_count = 0;
    int words_sent = 0;
    int results_seen = 0;
    int degenerate_seen = 0;
    int last_seen = 0;
    int config_writes = 0;
    bit no_idle = 1'b0;   // when set, neither side inserts gaps

    // Mirror of the unit's state.
    longint      query_mem[MAX_QUERY_LEN];
    longint      window_mem[MAX_QUERY_LEN];
    int unsigned win_len, ser_len, q_fill, ring_ptr, ser_pos;
    longint      q_sum, q_sq, w_sum, w_sq;
    bit          q_ready;

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void restart_series();
        ser_pos = 0;
        ring_ptr = 0;
        w_sum = 0;
        w_sq = 0;
    endfunction

    function automatic void drop_query();
        q_fill = 0;
        q_ready = 1'b0;
        q_sum = 0;
        q_sq = 0;
    endfunction

    function automatic void apply_config(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        int unsigned v;
        if (idx == REG_QUERY_LENGTH) begin
            v = data[MLEN_W-1:0];
            if (v < MLEN_MIN) v = MLEN_MIN;
            if (v > MAX_QUERY_LEN) v = MAX_QUERY_LEN;
            win_len = v;
        end else begin
            v = data;
            if (v < SLEN_MIN) v = SLEN_MIN;
            ser_len = v;
        end
        drop_query();
        restart_series();
    endfunction

    // Distance between the stored query and the newest win_len window samples.
    function automatic t_dist_result window_distance();
        t_dist_result r;
        longint m, dot, vq, vw, cov;
        longint unsigned mag, den, num, c, rem, t;
        int unsigned idx;
        m = win_len;
        dot = 0;
        for (int unsigned i = 0; i < win_len; i++) begin
            idx = (ring_ptr + MAX_QUERY_LEN - (win_len - 1) + i) % MAX_QUERY_LEN;
            dot += query_mem[i] * window_mem[idx];
        end
        vq = m * q_sq - q_sum * q_sum;
        vw = m * w_sq - w_sum * w_sum;
        r = '0;
        if (vq == 0 || vw == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        cov = m * dot - q_sum * w_sum;
        mag = (cov < 0) ? -cov : cov;
        den = int_sqrt(vq << FRAC_SHIFT) * int_sqrt(vw << FRAC_SHIFT);
        num = mag << FRAC_SHIFT;
        if (num >= den) begin
            c = 64'd1 << CORR_BITS;
        end else begin
            // Restoring division for the Q1.30 correlation magnitude.
            rem = num;
            c = 0;
            for (int k = 0; k < CORR_BITS; k++) begin
                rem <<= 1;
                c <<= 1;
                if (rem >= den) begin
                    rem -= den;
                    c |= 1;
                end
            end
        end
        t = (cov >= 0) ? (64'd1 << CORR_BITS) - c : (64'd1 << CORR_BITS) + c;
        r.distance = DIST_W'(int_sqrt((64'd2 * win_len * t) << 2));
        return r;
    endfunction

    function automatic void predict_word(input logic mode, input logic signed [SAMPLE_BITS-1:0] smp);
        longint s, old;
        t_dist_result r;
        s = smp;
        if (mode == MODE_QUERY) begin
            if (q_fill == 0) begin
                q_sum = 0;
                q_sq = 0;
            end
            q_ready = 1'b0;
            query_mem[q_fill % MAX_QUERY_LEN] = s;
            q_sum += s;
            q_sq += s * s;
            q_fill++;
            if (q_fill >= win_len) begin
                q_fill = 0;
                q_ready = 1'b1;
                restart_series();
            end
            return;
        end
        // Series words are dropped until a complete query is held.
        if (!q_ready) return;
        if (ser_pos >= win_len) begin
            old = window_mem[(ring_ptr + MAX_QUERY_LEN - win_len) % MAX_QUERY_LEN];
            w_sum -= old;
            w_sq -= old * old;
        end
        window_mem[ring_ptr] = s;
        w_sum += s;
        w_sq += s * s;
        if (ser_pos + 1 >= win_len) begin
            r = window_distance();
            r.window_start = POS_W'(ser_pos + 1 - win_len);
            r.last_of_series = (ser_pos + 1 == ser_len);
            dist_q.push_back(r);
        end
        ring_ptr = (ring_ptr + 1) % MAX_QUERY_LEN;
        ser_pos++;
        if (ser_pos >= ser_len) restart_series();
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int draw_gap();
        int p;
        if (no_idle) return 0;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    // Driver: presents the next queued word once the previous one is taken.
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_word(in_ch.mode, in_ch.sample);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (word_q.size() != 0) begin
                    w = word_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.mode <= w.mode;
                    in_ch.sample <= w.sample;
                    send_gap = draw_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes results with random back-pressure and checks each one.
    int recv_gap = 0;
    always @(posedge i_clk) begin
        t_dist_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (dist_q.size() == 0) begin
                    report("unexpected result, window_start", out_ch.window_start, -1);
                end else begin
                    want = dist_q.pop_front();
                    if (want.degenerate) degenerate_seen++;
                    if (want.last_of_series) last_seen++;
                    if (out_ch.distance !== want.distance)
                        report("distance", out_ch.distance, want.distance);
                    if (out_ch.window_start !== want.window_start)
                        report("window_start", out_ch.window_start, want.window_start);
                    if (out_ch.degenerate !== want.degenerate)
                        report("degenerate", out_ch.degenerate, want.degenerate);
                    if (out_ch.last_of_series !== want.last_of_series)
                        report("last_of_series", out_ch.last_of_series, want.last_of_series);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                recv_gap = draw_gap();
            end
        end
    end

    task automatic push_word(input logic mode, input logic signed [SAMPLE_BITS-1:0] smp);
        t_word w;
        w.mode = mode;
        w.sample = smp;
        word_q.push_back(w);
        words_sent++;
    endtask

    // Waits until the sender is drained and every owed result has come back.
    task automatic wait_drained();
        while (word_q.size() != 0 || in_ch.valid || dist_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Register writes happen only with the unit idle; a word that gives no
    // result may still be in flight, so a settling pause comes first.
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_config(idx, data);
        i_cfg_we <= 1'b0;
        config_writes++;
    endtask

    // Sample values: full range, small range, or a rail.
    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input int style);
        case (style)
            0: return SAMPLE_BITS'($urandom());
            1: return SAMPLE_BITS'($signed($urandom_range(0, 200)) - 100);
            default: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    task automatic load_query(input bit flat);
        logic signed [SAMPLE_BITS-1:0] base;
        int style;
        base = draw_sample(0);
        style = $urandom_range(0, 3);
        for (int unsigned i = 0; i < win_len; i++)
            push_word(MODE_QUERY, flat ? base : draw_sample(style > 2 ? 2 : style % 2));
    endtask

    initial begin
        int unsigned span, m_pick, n_pick;
        int style, p;
        logic signed [SAMPLE_BITS-1:0] held;

        win_len = MLEN_RESET;
        ser_len = SLEN_RESET;
        drop_query();
        restart_series();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part. Series words before any query are ignored.
        write_reg(REG_SERIES_LENGTH, 16'd5);
        write_reg(REG_QUERY_LENGTH, 16'd3);
        push_word(MODE_SERIES, 16'sd7);
        push_word(MODE_QUERY, 16'sh7fff);
        push_word(MODE_QUERY, 16'sh8000);
        push_word(MODE_QUERY, 16'sd0);
        push_word(MODE_SERIES, 16'sh8000);
        push_word(MODE_SERIES, 16'sh7fff);
        push_word(MODE_SERIES, 16'sh7fff);   // first window
        push_word(MODE_SERIES, 16'sh7fff);   // flat window: zero variance
        push_word(MODE_SERIES, 16'sh8000);   // final window of the series
        push_word(MODE_SERIES, 16'sd1);
        // A new query word mid-series drops the ready query.
        push_word(MODE_QUERY, 16'sd5);
        push_word(MODE_SERIES, 16'sd9);
        push_word(MODE_QUERY, 16'sd5);
        push_word(MODE_QUERY, 16'sd5);       // flat query: zero variance
        push_word(MODE_SERIES, 16'sd1);
        push_word(MODE_SERIES, 16'sd2);
        push_word(MODE_SERIES, 16'sd3);
        // Out-of-range register values are clamped; high data bits are unused.
        write_reg(REG_QUERY_LENGTH, 16'hff01);
        write_reg(REG_SERIES_LENGTH, 16'd0);
        push_word(MODE_QUERY, 16'sd1);
        push_word(MODE_QUERY, -16'sd1);
        for (int i = 0; i < 4; i++) push_word(MODE_SERIES, draw_sample(0));
        // Series shorter than the query never fills a window.
        write_reg(REG_QUERY_LENGTH, 16'd4);
        push_word(MODE_QUERY, 16'sd1);
        push_word(MODE_QUERY, 16'sd2);
        push_word(MODE_QUERY, 16'sd3);
        push_word(MODE_QUERY, 16'sd4);
        for (int i = 0; i < 3; i++) push_word(MODE_SERIES, draw_sample(1));
        write_reg(REG_QUERY_LENGTH, 16'd255);    // clamps to the largest query
        write_reg(REG_SERIES_LENGTH, 16'hffff);

        // Random part: one setting of both length registers per phase, then a query and a series.
        while (words_sent < TARGET_WORDS) begin
            p = $urandom_range(0, 99);
            if (p < 8) m_pick = MAX_QUERY_LEN;
            else if (p < 20) m_pick = MLEN_MIN;
            else if (p < 25) m_pick = $urandom_range(129, 255);
            else m_pick = $urandom_range(2, 12);
            p = $urandom_range(0, 99);
            if (p < 10) n_pick = SLEN_MIN;
            else if (p < 20) n_pick = 16'hffff;
            else if (p < 30) n_pick = $urandom_range(0, 2);
            else n_pick = $urandom_range(3, 40);
            if ($urandom_range(0, 1) != 0) begin
                write_reg(REG_QUERY_LENGTH, (16'($urandom()) & 16'hff00) | m_pick[7:0]);
                write_reg(REG_SERIES_LENGTH, n_pick[15:0]);
            end else begin
                write_reg(REG_SERIES_LENGTH, n_pick[15:0]);
                write_reg(REG_QUERY_LENGTH, m_pick[7:0]);
            end
            no_idle = ($urandom_range(0, 4) == 0);
            load_query($urandom_range(0, 9) == 0);
            // Long queries are costly per window, so their series stay short.
            span = (win_len > 16) ? win_len + $urandom_range(0, 10)
                                  : $urandom_range(ser_len < 60 ? ser_len : 20, 60);
            style = $urandom_range(0, 2);
            held = draw_sample(0);
            for (int unsigned i = 0; i < span; i++) begin
                p = $urandom_range(0, 99);
                if (p < 2) push_word(MODE_QUERY, draw_sample(0));   // breaks the query
                else if (p < 12) push_word(MODE_SERIES, held);       // flat stretches
                else push_word(MODE_SERIES, draw_sample(style));
                if (p == 50) begin
                    // Hold the sender until every owed distance is back.
                    wait_drained();
                end
            end
            if ($urandom_range(0, 3) == 0 && q_fill != 0) load_query(1'b0);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d words, %0d register writes, %0d distances", words_sent,
                 config_writes, results_seen);
        $display("(%0d with zero variance, %0d closing a series).", degenerate_seen, last_seen);
        if (error_count == 0 && dist_q.size() == 0) begin
            $display("znorm_distance_profile_unit verification clean");
        end else begin
            $display("znorm_distance_profile_unit verification failed");
        end
        $finish;
    end

    // Watchdog: generous bound over the slowest legal run.
    initial begin
        #40ms;
        $display("znorm_distance_profile_unit verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/zdp_pkg.sv
rtl/core/zdp_in_if.sv
rtl/core/zdp_out_if.sv
rtl/core/zdp_ram.sv
rtl/core/zdp_sqrt.sv
rtl/core/zdp_div.sv
rtl/core/znorm_distance_profile_unit.sv
tb/znorm_distance_profile_unit_tb.sv
